FILE: hdl/inverse_square_gravity_accel_core_macros.svh
// assertion macros shared by the core's modules
`ifndef INVERSE_SQUARE_GRAVITY_ACCEL_CORE_MACROS_SVH
`define INVERSE_SQUARE_GRAVITY_ACCEL_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ISGA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("isga check failed");
`define ISGA_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isga sequence check failed");
`else
`define ISGA_ASSERT(lbl, cond)
`define ISGA_IMPLY(lbl, ante, cons)
`endif
`endif

FILE: hdl/isga_pkg.sv
// ----------------------------------------------------------------------------
// isga_pkg
// widths, payload types and register codes of the gravity acceleration core
// ----------------------------------------------------------------------------
package isga_pkg;

  localparam int POS_BITS  = 24;
  localparam int FRAC_DEF  = 16;
  localparam int MAG_W     = POS_BITS;
  localparam int D2_W      = 2 * POS_BITS;
  localparam int ROOT_W    = POS_BITS;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DEN_W     = 3 * POS_BITS;
  localparam int PARAM_W   = 48;
  localparam int HALF_W    = PARAM_W / 2;
  localparam int PART_W    = HALF_W + MAG_W;
  localparam int PROD_W    = PARAM_W + MAG_W;
  localparam int ACC_W     = 48;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 64;
  localparam int CFG_IDX_LSB = 3;

  typedef enum logic {
    REG_GRAV_PARAM = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] acc_z;
    logic                    saturated;
    logic                    zero_distance;
  } out_t;

  // one stage of the distance pipeline
  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0][D2_W-1:0]   sq;
    logic [2:0][PART_W-1:0] plo;
    logic [2:0][PART_W-1:0] phi;
    logic [2:0][PROD_W-1:0] prod;
    logic [D2_W-1:0]        d2;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic [D2_W-1:0]        dlo;
    logic [D2_W-1:0]        dhi;
    logic [DEN_W-1:0]       den;
    logic                   zero;
  } dist_stage_t;

  // hand-off from distance pipeline to divider pipeline
  typedef struct packed {
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0]             neg;
    logic [DEN_W-1:0]       den;
    logic                   zero;
  } dist_t;

endpackage

FILE: hdl/inverse_square_gravity_accel_core.sv
// ----------------------------------------------------------------------------
// inverse_square_gravity_accel_core
// two-body newtonian acceleration a = -mu * r / |r|^3 in fixed point
// ----------------------------------------------------------------------------
//  channel   ports                          payload / role
//  in        in_valid, in_stall, in_data    relative position x, y, z
//  out       out_valid, out_stall, out_data acceleration x, y, z and flags
//  cfg       psel .. pready (apb style)     grav_param at byte address 0
//
//  one transfer enters per cycle while in_stall is low; out_valid rises once the
//  transfer has passed 5 + POS_BITS stages for distance, root and d^3, a
//  prescale stage, 48 divider stages with one quotient bit each, and then
//  the output register
//  reset (rst_n low, synchronous) empties every stage and clears grav_param
//  a stall freezes only full stages; bubbles ahead of it keep closing up, so
//  in_stall rises only once every stage between input and output is full
// ----------------------------------------------------------------------------
`include "inverse_square_gravity_accel_core_macros.svh"
module inverse_square_gravity_accel_core import isga_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // position transfers
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  // acceleration transfers
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic               in_ready;
  logic [PARAM_W-1:0] grav_param;
  logic               mid_valid;
  logic               mid_ready;
  dist_t              mid_data;

  // mu lives here; the user must write it only while the pipeline is drained, which the block itself does not enforce
  isga_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .grav_param (grav_param)
  );

  // |r_i|, d2, floor sqrt, d2*d and mu*|r_i|
  isga_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_data    (in_data),
    .grav_param (grav_param),
    .dn_valid   (mid_valid),
    .dn_ready   (mid_ready),
    .dn_data    (mid_data)
  );

  // mu*|r_i|*2^FRAC_BITS / (d2*d), clipped and signed
  isga_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_data   (mid_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !in_ready;

  // an output register that is free must never hold up the input
  `ISGA_ASSERT(a_free_out, out_valid || !in_stall)
  // a result that waits under stall keeps its payload
  `ISGA_IMPLY(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

FILE: hdl/isga_cfg.sv
// ----------------------------------------------------------------------------
// isga_cfg
// register file holding the gravitational parameter
// ----------------------------------------------------------------------------
module isga_cfg import isga_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [PARAM_W-1:0] grav_param
);

  logic [PARAM_W-1:0] gp_r, gp_nxt;
  cfg_reg_t           sel;

  assign sel    = cfg_reg_t'(paddr[CFG_IDX_LSB]);
  assign pready = 1'b1;

  always_comb begin
    gp_nxt = gp_r;
    if (psel && penable && pwrite) begin
      unique case (sel)
        REG_GRAV_PARAM: gp_nxt = pwdata[PARAM_W-1:0];
        default:        gp_nxt = gp_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_GRAV_PARAM: prdata = CFG_DW'(gp_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= '0;
    end else begin
      gp_r <= gp_nxt;
    end
  end

  assign grav_param = gp_r;

endmodule

FILE: hdl/isga_dist.sv
// ----------------------------------------------------------------------------
// isga_dist
// magnitudes, squared distance, bitwise square root, d^3 and mu*|r| products
// ----------------------------------------------------------------------------
`include "inverse_square_gravity_accel_core_macros.svh"
module isga_dist import isga_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  in_t                up_data,
  input  logic [PARAM_W-1:0] grav_param,
  output logic               dn_valid,
  input  logic               dn_ready,
  output dist_t              dn_data
);

  localparam int NS   = 5 + POS_BITS;
  localparam int SQ0  = 3;
  localparam int DEN1 = 3 + POS_BITS;
  localparam int DEN2 = 4 + POS_BITS;

  dist_stage_t    st_r   [NS];
  dist_stage_t    st_nxt [NS];
  logic [NS-1:0]  v_r;
  logic [NS-1:0]  rdy;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_st
      if (k == 0) begin : g_mag
        always_comb begin
          logic [2:0][POS_BITS-1:0] p;
          p[0] = up_data.pos_x;
          p[1] = up_data.pos_y;
          p[2] = up_data.pos_z;
          st_nxt[0] = '0;
          for (int c = 0; c < 3; c++) begin
            st_nxt[0].neg[c] = p[c][POS_BITS-1];
            st_nxt[0].mag[c] = p[c][POS_BITS-1] ? MAG_W'(~p[c] + 1'b1) : p[c];
          end
        end
      end else if (k == 1) begin : g_mul
        always_comb begin
          st_nxt[1] = st_r[0];
          for (int c = 0; c < 3; c++) begin
            st_nxt[1].sq[c]  = D2_W'(st_r[0].mag[c]) * D2_W'(st_r[0].mag[c]);
            st_nxt[1].plo[c] = PART_W'(grav_param[HALF_W-1:0]) * PART_W'(st_r[0].mag[c]);
            st_nxt[1].phi[c] = PART_W'(grav_param[PARAM_W-1:HALF_W])
                               * PART_W'(st_r[0].mag[c]);
          end
        end
      end else if (k == 2) begin : g_sum
        always_comb begin
          st_nxt[2] = st_r[1];
          st_nxt[2].d2 = st_r[1].sq[0] + st_r[1].sq[1] + st_r[1].sq[2];
          for (int c = 0; c < 3; c++) begin
            st_nxt[2].prod[c] = (PROD_W'(st_r[1].phi[c]) << HALF_W)
                                + PROD_W'(st_r[1].plo[c]);
          end
          st_nxt[2].rem  = '0;
          st_nxt[2].root = '0;
        end
      end else if (k < DEN1) begin : g_sqrt
        // one root bit per stage, two radicand bits consumed
        localparam int J = k - SQ0;
        always_comb begin
          logic [REM_W-1:0] remx;
          logic [REM_W-1:0] trial;
          st_nxt[k] = st_r[k-1];
          remx  = REM_W'({st_r[k-1].rem, st_r[k-1].d2[2*(POS_BITS-1-J) +: 2]});
          trial = REM_W'({st_r[k-1].root, 2'b01});
          if (remx >= trial) begin
            st_nxt[k].rem  = remx - trial;
            st_nxt[k].root = {st_r[k-1].root[ROOT_W-2:0], 1'b1};
          end else begin
            st_nxt[k].rem  = remx;
            st_nxt[k].root = {st_r[k-1].root[ROOT_W-2:0], 1'b0};
          end
        end
      end else if (k == DEN1) begin : g_dmul
        always_comb begin
          st_nxt[k] = st_r[k-1];
          st_nxt[k].dlo = D2_W'(st_r[k-1].d2[POS_BITS-1:0]) * D2_W'(st_r[k-1].root);
          st_nxt[k].dhi = D2_W'(st_r[k-1].d2[D2_W-1:POS_BITS]) * D2_W'(st_r[k-1].root);
        end
      end else begin : g_dsum
        always_comb begin
          st_nxt[k] = st_r[k-1];
          st_nxt[k].den  = (DEN_W'(st_r[k-1].dhi) << POS_BITS) + DEN_W'(st_r[k-1].dlo);
          st_nxt[k].zero = (st_r[k-1].d2 == '0);
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          st_r[k] <= st_nxt[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  assign dn_valid     = v_r[NS-1];
  assign dn_data.prod = st_r[NS-1].prod;
  assign dn_data.neg  = st_r[NS-1].neg;
  assign dn_data.den  = st_r[NS-1].den;
  assign dn_data.zero = st_r[NS-1].zero;

  `ISGA_ASSERT(a_zero_den, !v_r[NS-1] || (st_r[NS-1].zero == (st_r[NS-1].den == '0)))
  `ISGA_ASSERT(a_ready_empty, v_r != '0 || up_ready)

endmodule

FILE: hdl/isga_div.sv
// ----------------------------------------------------------------------------
// isga_div
// restoring divider pipeline, saturation and sign, output register
// ----------------------------------------------------------------------------
`include "inverse_square_gravity_accel_core_macros.svh"
module isga_div import isga_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  dist_t up_data,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int NUM_W = PROD_W + FRAC_BITS;
  localparam int TOP_W = DEN_W + ACC_W;
  localparam int W     = ((NUM_W > TOP_W) ? NUM_W : TOP_W) + 1;
  localparam int NS    = ACC_W + 1;
  localparam logic [ACC_W-1:0] LIM_POS = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] LIM_NEG = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0]     rem;
    logic [2:0][ACC_W-1:0] q;
    logic [2:0]            ovf;
    logic [2:0]            neg;
    logic [DEN_W-1:0]      den;
    logic                  zero;
  } div_stage_t;

  div_stage_t    st_r   [NS];
  div_stage_t    st_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;
  logic          rdy_out;
  logic          out_valid_r;
  out_t          out_r, out_nxt;

  assign rdy_out = !out_valid_r || !out_stall;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || rdy_out;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready = rdy[0];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_st
      if (k == 0) begin : g_pre
        // quotient of 2^ACC_W or more always clips
        always_comb begin
          st_nxt[0]      = '0;
          st_nxt[0].neg  = up_data.neg;
          st_nxt[0].den  = up_data.den;
          st_nxt[0].zero = up_data.zero;
          for (int c = 0; c < 3; c++) begin
            st_nxt[0].rem[c] = W'(up_data.prod[c]) << FRAC_BITS;
            st_nxt[0].ovf[c] = st_nxt[0].rem[c] >= (W'(up_data.den) << ACC_W);
          end
        end
      end else begin : g_bit
        localparam int I = ACC_W - k;
        always_comb begin
          logic [W-1:0] t;
          st_nxt[k] = st_r[k-1];
          t = W'(st_r[k-1].den) << I;
          for (int c = 0; c < 3; c++) begin
            if (st_r[k-1].rem[c] >= t) begin
              st_nxt[k].rem[c]  = st_r[k-1].rem[c] - t;
              st_nxt[k].q[c][I] = 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          st_r[k] <= st_nxt[k];
        end
      end
    end
  endgenerate

  // clip, apply sign (result points against the position)
  always_comb begin
    logic [2:0][ACC_W-1:0] acc;
    logic [ACC_W-1:0]      lim;
    logic [ACC_W-1:0]      qq;
    logic                  sat;
    logic                  clip;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lim  = st_r[NS-1].neg[c] ? LIM_POS : LIM_NEG;
      clip = st_r[NS-1].ovf[c] || (st_r[NS-1].q[c] > lim);
      qq   = clip ? lim : st_r[NS-1].q[c];
      sat  = sat || clip;
      acc[c] = st_r[NS-1].neg[c] ? qq : ACC_W'(~qq + 1'b1);
    end
    if (st_r[NS-1].zero) begin
      acc = '0;
      sat = 1'b0;
    end
    out_nxt.acc_x         = acc[0];
    out_nxt.acc_y         = acc[1];
    out_nxt.acc_z         = acc[2];
    out_nxt.saturated     = sat;
    out_nxt.zero_distance = st_r[NS-1].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
      if (rdy_out) begin
        out_valid_r <= v_r[NS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ISGA_ASSERT(a_zero_out, !out_valid_r || !out_r.zero_distance || (out_r.acc_x == '0 && out_r.acc_y == '0 && out_r.acc_z == '0 && !out_r.saturated))
  `ISGA_IMPLY(a_last_moves, v_r[NS-1] && rdy_out, out_valid_r)

endmodule

FILE: dv/isga_accel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isga_accel_checker
// tracks grav_param from register writes, computes the acceleration of each
// position transfer and compares it with the result transfers in order
// ----------------------------------------------------------------------------
module isga_accel_checker import isga_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fail_count,
  output int                accel_pending,
  output int                results_seen
);

  localparam int FRAC = FRAC_DEF;

  logic [PARAM_W-1:0] mu;
  out_t               accel_due[$];

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  assign accel_pending = accel_due.size();

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] rem, res, bit_v;
    rem = x;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic out_t gravity_accel(input in_t p, input logic [PARAM_W-1:0] g);
    out_t                  a;
    logic [2:0][POS_BITS-1:0] raw;
    logic [POS_BITS:0]     mag[3];
    logic                  neg[3];
    logic [63:0]           d2, d;
    logic [127:0]          den, num, q, lim;
    logic [ACC_W-1:0]      comp[3];
    a = '0;
    raw = {p.pos_x, p.pos_y, p.pos_z};
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[2-i][POS_BITS-1];
      mag[i] = neg[i] ? (({1'b1, {POS_BITS{1'b0}}}) - {1'b0, raw[2-i]}) : {1'b0, raw[2-i]};
      d2 = d2 + 64'(mag[i]) * 64'(mag[i]);
    end
    if (d2 == 0) begin
      a.zero_distance = 1'b1;
      return a;
    end
    d = floor_root(d2);
    den = 128'(d2) * 128'(d);
    for (int i = 0; i < 3; i++) begin
      comp[i] = '0;
      if (mag[i] != 0 && g != 0) begin
        num = (128'(g) * 128'(mag[i])) << FRAC;
        q = num / den;
        // a negative position gives a positive acceleration
        lim = neg[i] ? ((128'd1 << (ACC_W-1)) - 1) : (128'd1 << (ACC_W-1));
        if (q > lim) begin
          a.saturated = 1'b1;
          q = lim;
        end
        comp[i] = neg[i] ? q[ACC_W-1:0] : (ACC_W'(0) - q[ACC_W-1:0]);
      end
    end
    a.acc_x = comp[0];
    a.acc_y = comp[1];
    a.acc_z = comp[2];
    return a;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      mu = '0;
      accel_due.delete();
    end else begin
      if (in_valid && !in_stall) accel_due.push_back(gravity_accel(in_data, mu));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (accel_due.size() == 0) begin
          $display("mismatch at %0t: result transfer with nothing outstanding", $time);
          fail_count++;
        end else begin
          want = accel_due.pop_front();
          if (out_data.acc_x !== want.acc_x) report("acc_x", out_data.acc_x, want.acc_x);
          if (out_data.acc_y !== want.acc_y) report("acc_y", out_data.acc_y, want.acc_y);
          if (out_data.acc_z !== want.acc_z) report("acc_z", out_data.acc_z, want.acc_z);
          if (out_data.saturated !== want.saturated)
            report("saturated", out_data.saturated, want.saturated);
          if (out_data.zero_distance !== want.zero_distance)
            report("zero_distance", out_data.zero_distance, want.zero_distance);
        end
      end
      if (psel && penable && pwrite && pready && paddr[CFG_IDX_LSB-1:0] == '0 &&
          paddr[CFG_AW-1:CFG_IDX_LSB] == REG_GRAV_PARAM)
        mu = pwdata[PARAM_W-1:0];
    end
  end

endmodule

FILE: dv/inverse_square_gravity_accel_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_square_gravity_accel_core_tb
// streams position vectors through the gravity core under several grav_param
// settings, with random gaps and stalls on both channels; a checker compares
// every acceleration transfer against its own fixed point calculation
// ----------------------------------------------------------------------------
module inverse_square_gravity_accel_core_tb;
  import isga_pkg::*;

  localparam int  LATENCY   = POS_BITS + 54;
  localparam int  DRAIN     = LATENCY + 20;
  localparam int  MAX_CYC   = 2_000_000;
  localparam int  RAND_ITEMS = 370;    // per grav_param phase, five phases
  localparam int  HOLD_CYC  = 600;     // long receiver hold-off

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int  fail_count;
  int  accel_pending;
  int  results_seen;
  int  cycle_count;
  bit  no_gaps;      // burst stretches: neither side idles
  bit  hold_done;
  int  items_sent;

  inverse_square_gravity_accel_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  isga_accel_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .accel_pending(accel_pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= MAX_CYC) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one transfer of a position vector; valid stays up between back-to-back items
  task automatic send_pos(input in_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // register write only with the pipe drained
  task automatic write_grav_param(input logic [PARAM_W-1:0] g);
    in_valid <= 1'b0;
    while (accel_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(REG_GRAV_PARAM) << CFG_IDX_LSB;
    pwdata  <= CFG_DW'(g);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [POS_BITS-1:0] rand_comp(input int kind);
    logic signed [POS_BITS-1:0] v;
    case (kind)
      0: v = POS_BITS'($urandom);
      1: v = POS_BITS'($signed($urandom_range(0, 510)) - 255);
      2: v = 0;
      3: v = $urandom_range(0, 1) ? {1'b1, {(POS_BITS-1){1'b0}}}
                                  : {1'b0, {(POS_BITS-1){1'b1}}};
      default: v = POS_BITS'($signed($urandom_range(0, 131070)) - 65535);
    endcase
    return v;
  endfunction

  function automatic in_t rand_pos();
    in_t p;
    int  mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) return '0;
    if (mode < 8) begin
      p.pos_x = rand_comp(0);
      p.pos_y = rand_comp(0);
      p.pos_z = rand_comp(0);
    end else begin
      p.pos_x = rand_comp($urandom_range(0, 4));
      p.pos_y = rand_comp($urandom_range(0, 4));
      p.pos_z = rand_comp($urandom_range(0, 4));
    end
    return p;
  endfunction

  // directed vectors: zero vector, field extremes, lone components, signs
  task automatic send_directed();
    logic signed [POS_BITS-1:0] mx, mn;
    mx = {1'b0, {(POS_BITS-1){1'b1}}};
    mn = {1'b1, {(POS_BITS-1){1'b0}}};
    send_pos('{pos_x: 0, pos_y: 0, pos_z: 0});
    send_pos('{pos_x: 1, pos_y: 0, pos_z: 0});
    send_pos('{pos_x: 0, pos_y: -1, pos_z: 0});
    send_pos('{pos_x: 0, pos_y: 0, pos_z: 1});
    send_pos('{pos_x: -1, pos_y: 1, pos_z: -1});
    send_pos('{pos_x: mx, pos_y: mx, pos_z: mx});
    send_pos('{pos_x: mn, pos_y: mn, pos_z: mn});
    send_pos('{pos_x: mx, pos_y: mn, pos_z: 0});
    send_pos('{pos_x: mn, pos_y: 0, pos_z: 0});
    send_pos('{pos_x: 0, pos_y: mx, pos_z: 0});
    send_pos('{pos_x: 3, pos_y: 4, pos_z: 12});
    send_pos('{pos_x: -1000, pos_y: 2000, pos_z: -3000});
    send_pos('{pos_x: mn, pos_y: 1, pos_z: -1});
    send_pos('{pos_x: 0, pos_y: 0, pos_z: 0});
  endtask

  // receiver: random stall per transfer, one long hold-off to fill the pipe
  initial begin
    int wait_cyc;
    out_stall = 1'b1;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
      end
      wait_cyc = no_gaps ? 0 : $urandom_range(0, 12);
      if (wait_cyc > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cyc) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [PARAM_W-1:0] phase_mu[5];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    no_gaps    = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grav_param left at reset value (0) for the directed set first
    send_directed();

    phase_mu[0] = 48'd1;
    phase_mu[1] = {PARAM_W{1'b1}};
    phase_mu[2] = PARAM_W'({$urandom, $urandom});
    phase_mu[3] = PARAM_W'($urandom_range(1, 1 << 20));
    phase_mu[4] = 48'd0;
    for (int ph = 0; ph < 5; ph++) begin
      write_grav_param(phase_mu[ph]);
      if (ph < 2) send_directed();
      for (int n = 0; n < RAND_ITEMS; n++) begin
        // a burst stretch with no idling in every phase
        no_gaps = (n >= 100 && n < 160);
        send_pos(rand_pos());
      end
      no_gaps = 1'b0;
    end
    in_valid <= 1'b0;

    while (accel_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d position vectors sent, %0d accelerations checked over six grav_param settings",
             items_sent, results_seen);
    $display("included zero vectors, extreme components, saturation and a long output hold-off");
    if (fail_count == 0 && accel_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/isga_pkg.sv
hdl/isga_cfg.sv
hdl/isga_dist.sv
hdl/isga_div.sv
hdl/inverse_square_gravity_accel_core.sv
dv/isga_accel_checker.sv
dv/inverse_square_gravity_accel_core_tb.sv
